// ===== rtl/pds_pkg.sv =====
// Shared types and constants for the pixel difference statistics core.
// No dependencies; imported by pds_pixel_math and pixel_diff_statistics_core.
`default_nettype none

package pds_pkg;

  localparam int PIX_W      = 8;
  localparam int SUM_W      = 10;
  localparam int COUNT_W    = 23;
  localparam int TOTAL_W    = 32;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 72;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam int MAX_PIXELS_DEFAULT = 4194304;
  localparam int COUNT_FIELD_MAX    = 8388607;

  localparam logic [PIX_W-1:0] THRESHOLD_RESET = 8'd8;
  localparam logic [PIX_W-1:0] GAIN_RESET      = 8'd6;
  localparam logic [PIX_W-1:0] LEVEL_MAX       = 8'd255;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX     = 32'hFFFF_FFFF;

  // register select, taken from paddr[2]
  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_GAIN      = 1'b1;

  // first_blue in the lowest bits, matching the tdata layout
  typedef struct packed {
    logic [PIX_W-1:0] second_red;
    logic [PIX_W-1:0] second_green;
    logic [PIX_W-1:0] second_blue;
    logic [PIX_W-1:0] first_red;
    logic [PIX_W-1:0] first_green;
    logic [PIX_W-1:0] first_blue;
  } pixel_pair_t;

  typedef struct packed {
    logic [PIX_W-1:0] level;
    logic [PIX_W-1:0] peak;
    logic [SUM_W-1:0] sum;
  } pixel_metrics_t;

endpackage

`default_nettype wire

// ===== rtl/pds_pixel_math.sv =====
// Per-pixel difference math: channel absolute differences, their sum,
// largest channel difference and the amplified saturated level. Uses pds_pkg.
`default_nettype none

module pds_pixel_math (
  input  var pds_pkg::pixel_pair_t    pair,
  input  var logic [7:0]              gain,
  output var pds_pkg::pixel_metrics_t metrics
);
  import pds_pkg::*;

  logic [PIX_W-1:0]       db;
  logic [PIX_W-1:0]       dg;
  logic [PIX_W-1:0]       dr;
  logic [PIX_W-1:0]       mx_bg;
  logic [SUM_W+PIX_W-1:0] prod;

  always_comb begin
    db = (pair.first_blue > pair.second_blue) ? pair.first_blue - pair.second_blue
                                              : pair.second_blue - pair.first_blue;
    dg = (pair.first_green > pair.second_green) ? pair.first_green - pair.second_green
                                                : pair.second_green - pair.first_green;
    dr = (pair.first_red > pair.second_red) ? pair.first_red - pair.second_red
                                            : pair.second_red - pair.first_red;
    mx_bg = (dg > db) ? dg : db;
    metrics.peak = (dr > mx_bg) ? dr : mx_bg;
    metrics.sum  = SUM_W'(db) + SUM_W'(dg) + SUM_W'(dr);
    prod = (SUM_W+PIX_W)'(metrics.sum) * (SUM_W+PIX_W)'(gain);
    metrics.level = (prod > (SUM_W+PIX_W)'(LEVEL_MAX)) ? LEVEL_MAX : prod[PIX_W-1:0];
  end

endmodule

`default_nettype wire

// ===== rtl/pixel_diff_statistics_core.sv =====
// Top level: input register, pixel math, frame statistics and result register.
// Input register, then result register; 1 pixel per cycle unless m_tready stalls the result.
// The input register refills in the cycle the result register is taken or empty.
// Reset (rst, synchronous): pipeline empty, totals cleared, threshold 8, gain 6.
// Depends on pds_pkg and pds_pixel_math.
`default_nettype none

module pixel_diff_statistics_core #(
  parameter int MAX_PIXELS = pds_pkg::MAX_PIXELS_DEFAULT
) (
  input  var logic                           clk,
  input  var logic                           rst,
  // tdata: first_blue, first_green, first_red, second_blue, second_green, second_red
  input  var logic [pds_pkg::IN_DATA_W-1:0]  s_tdata,
  input  var logic                           s_tlast,
  input  var logic                           s_tvalid,
  output var logic                           s_tready,
  // tdata: diff_level, over_count, peak_difference, difference_total, zero pad
  output var logic [pds_pkg::OUT_DATA_W-1:0] m_tdata,
  output var logic                           m_tlast,
  output var logic                           m_tvalid,
  input  var logic                           m_tready,
  input  var logic                           psel,
  input  var logic                           penable,
  input  var logic                           pwrite,
  input  var logic [pds_pkg::CFG_ADDR_W-1:0] paddr,
  input  var logic [pds_pkg::CFG_DATA_W-1:0] pwdata,
  output var logic [pds_pkg::CFG_DATA_W-1:0] prdata,
  output var logic                           pready
);
  import pds_pkg::*;

  localparam int COUNT_LIMIT_I = (MAX_PIXELS < COUNT_FIELD_MAX) ? MAX_PIXELS : COUNT_FIELD_MAX;
  localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(COUNT_LIMIT_I);

  logic [PIX_W-1:0]   diff_threshold;
  logic [PIX_W-1:0]   amplify_gain;
  logic               cfg_write;

  logic               in_valid;
  pixel_pair_t        in_pair;
  logic               in_last;
  logic               advance;
  pixel_metrics_t     metrics;

  logic [COUNT_W-1:0] running_count;
  logic [PIX_W-1:0]   running_peak;
  logic [TOTAL_W-1:0] running_total;
  logic [COUNT_W-1:0] count_next;
  logic [PIX_W-1:0]   peak_next;
  logic [TOTAL_W-1:0] total_next;
  logic [TOTAL_W:0]   total_sum;

  logic [PIX_W-1:0]   out_level;
  logic [COUNT_W-1:0] out_count;
  logic [PIX_W-1:0]   out_peak;
  logic [TOTAL_W-1:0] out_total;

  // configuration
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      diff_threshold <= THRESHOLD_RESET;
      amplify_gain   <= GAIN_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_THRESHOLD: diff_threshold <= pwdata[PIX_W-1:0];
        REG_GAIN:      amplify_gain   <= pwdata[PIX_W-1:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_THRESHOLD: prdata = CFG_DATA_W'(diff_threshold);
      REG_GAIN:      prdata = CFG_DATA_W'(amplify_gain);
      default:       prdata = '0;
    endcase
  end

  // pipeline control
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_pair <= pixel_pair_t'(s_tdata);
      in_last <= s_tlast;
    end
  end

  pds_pixel_math u_math (
    .pair    (in_pair),
    .gain    (amplify_gain),
    .metrics (metrics)
  );

  // frame statistics, including the current pixel
  always_comb begin
    count_next = running_count;
    if (metrics.peak > diff_threshold && running_count < COUNT_LIMIT) begin
      count_next = running_count + COUNT_W'(1);
    end
    peak_next = (metrics.peak > running_peak) ? metrics.peak : running_peak;
    total_sum = {1'b0, running_total} + (TOTAL_W+1)'(metrics.sum);
    total_next = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_count <= '0;
      running_peak  <= '0;
      running_total <= '0;
    end else if (advance) begin
      if (in_last) begin
        running_count <= '0;
        running_peak  <= '0;
        running_total <= '0;
      end else begin
        running_count <= count_next;
        running_peak  <= peak_next;
        running_total <= total_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_level <= metrics.level;
      m_tlast   <= in_last;
      out_count <= in_last ? count_next : '0;
      out_peak  <= in_last ? peak_next  : '0;
      out_total <= in_last ? total_next : '0;
    end
  end

  assign m_tdata = {1'b0, out_total, out_peak, out_count, out_level};

  // checks
  a_accept_when_free: assert property (@(posedge clk) disable iff (rst)
    (!m_tvalid || m_tready) |-> s_tready)
    else $error("input stalled while result side is free");

  a_stats_zero_midframe: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> (out_count == '0 && out_peak == '0 && out_total == '0))
    else $error("frame totals reported on a pixel that is not last");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $past(advance && in_last)) |->
      (running_count == '0 && running_peak == '0 && running_total == '0))
    else $error("frame totals not cleared after last pixel");

  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    running_count <= COUNT_LIMIT)
    else $error("pixel count beyond its limit");

endmodule

`default_nettype wire

// ===== bench/diff_stats_checker.sv =====
// Checker for pixel_diff_statistics_core: follows the pixel, result and register
// traffic, predicts each result and compares it with what the core returns.
// Depends on pds_pkg.
module diff_stats_checker #(
  parameter int MAX_PIXELS = pds_pkg::MAX_PIXELS_DEFAULT
) (
  input  var logic                           clk,
  input  var logic                           rst,
  input  var logic [pds_pkg::IN_DATA_W-1:0]  s_tdata,
  input  var logic                           s_tlast,
  input  var logic                           s_tvalid,
  input  var logic                           s_tready,
  input  var logic [pds_pkg::OUT_DATA_W-1:0] m_tdata,
  input  var logic                           m_tlast,
  input  var logic                           m_tvalid,
  input  var logic                           m_tready,
  input  var logic                           psel,
  input  var logic                           penable,
  input  var logic                           pwrite,
  input  var logic [pds_pkg::CFG_ADDR_W-1:0] paddr,
  input  var logic [pds_pkg::CFG_DATA_W-1:0] pwdata,
  input  var logic [pds_pkg::CFG_DATA_W-1:0] prdata,
  input  var logic                           pready,
  output int                                 mismatch_count,
  output int                                 outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import pds_pkg::*;

  localparam int COUNT_CAP = (MAX_PIXELS < COUNT_FIELD_MAX) ? MAX_PIXELS : COUNT_FIELD_MAX;

  typedef struct packed {
    logic [PIX_W-1:0]   level;
    logic               done;
    logic [COUNT_W-1:0] over_count;
    logic [PIX_W-1:0]   peak;
    logic [TOTAL_W-1:0] total;
  } frame_result_t;

  logic [PIX_W-1:0]   threshold;
  logic [PIX_W-1:0]   gain;
  logic [COUNT_W-1:0] run_count;
  logic [PIX_W-1:0]   run_peak;
  logic [TOTAL_W-1:0] run_total;
  frame_result_t      pending_results[$];
  int                 errors = 0;

  function automatic logic [PIX_W-1:0] channel_gap(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic pixel_pair_t unpack_pair(logic [IN_DATA_W-1:0] d);
    pixel_pair_t px;
    px.first_blue   = d[7:0];
    px.first_green  = d[15:8];
    px.first_red    = d[23:16];
    px.second_blue  = d[31:24];
    px.second_green = d[39:32];
    px.second_red   = d[47:40];
    return px;
  endfunction

  // updates the frame totals and returns the result that this pixel produces
  function automatic frame_result_t advance_stats(pixel_pair_t px, logic last);
    logic [PIX_W-1:0] db, dg, dr, widest;
    logic [SUM_W-1:0] span;
    logic [17:0]      scaled;
    frame_result_t    r;
    db = channel_gap(px.first_blue, px.second_blue);
    dg = channel_gap(px.first_green, px.second_green);
    dr = channel_gap(px.first_red, px.second_red);
    span = SUM_W'(db) + SUM_W'(dg) + SUM_W'(dr);
    scaled = 18'(span) * 18'(gain);
    widest = db;
    if (dg > widest) widest = dg;
    if (dr > widest) widest = dr;
    if (widest > threshold && int'(run_count) < COUNT_CAP) run_count++;
    if (widest > run_peak) run_peak = widest;
    if (run_total > TOTAL_MAX - TOTAL_W'(span)) run_total = TOTAL_MAX;
    else run_total = run_total + TOTAL_W'(span);
    r = '0;
    r.level = (scaled > 18'd255) ? LEVEL_MAX : scaled[7:0];
    if (last) begin
      r.done = 1'b1;
      r.over_count = run_count;
      r.peak = run_peak;
      r.total = run_total;
      run_count = '0;
      run_peak = '0;
      run_total = '0;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= 10) $display("%0t ns: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    frame_result_t want, got;
    logic [CFG_DATA_W-1:0] reg_value;
    if (rst) begin
      threshold = THRESHOLD_RESET;
      gain = GAIN_RESET;
      run_count = '0;
      run_peak = '0;
      run_total = '0;
      pending_results.delete();
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[2] == REG_THRESHOLD) threshold = pwdata[PIX_W-1:0];
          else gain = pwdata[PIX_W-1:0];
        end else begin
          reg_value = (paddr[2] == REG_THRESHOLD) ? CFG_DATA_W'(threshold) : CFG_DATA_W'(gain);
          if (prdata !== reg_value)
            report_mismatch($sformatf("register read at %0d: expected %0d, actual %0d",
                                      paddr, reg_value, prdata));
        end
      end
      if (m_tvalid && m_tready) begin
        got.level      = m_tdata[7:0];
        got.done       = m_tlast;
        got.over_count = m_tdata[30:8];
        got.peak       = m_tdata[38:31];
        got.total      = m_tdata[70:39];
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result with none outstanding: level=%0d done=%0b",
                                    got.level, got.done));
        end else begin
          want = pending_results.pop_front();
          if (got !== want)
            report_mismatch($sformatf({"result mismatch: expected level=%0d done=%0b ",
                                       "count=%0d peak=%0d total=%0d, actual level=%0d ",
                                       "done=%0b count=%0d peak=%0d total=%0d"},
                                      want.level, want.done, want.over_count, want.peak,
                                      want.total, got.level, got.done, got.over_count,
                                      got.peak, got.total));
        end
      end
      if (s_tvalid && s_tready)
        pending_results = {pending_results, advance_stats(unpack_pair(s_tdata), s_tlast)};
    end
    outstanding <= pending_results.size();
    mismatch_count <= errors;
  end

endmodule

// ===== bench/pixel_diff_statistics_core_test.sv =====
// Top of the pixel_diff_statistics_core bench: clock, reset, pixel frames, register
// writes and random back-pressure. Results are judged by diff_stats_checker.
// Depends on pds_pkg, pixel_diff_statistics_core and diff_stats_checker.
module pixel_diff_statistics_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import pds_pkg::*;

  // small cap so that long frames reach the pixel count limit
  localparam int PIXEL_CAP = 48;

  logic                  clk;
  logic                  rst;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  s_tlast;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;
  logic                  m_tvalid;
  logic                  m_tready;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  int                    mismatch_count;
  int                    outstanding;
  int                    pixels_sent = 0;

  pixel_diff_statistics_core #(.MAX_PIXELS(PIXEL_CAP)) DUT (.*);

  diff_stats_checker #(.MAX_PIXELS(PIXEL_CAP)) stats_check (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3ms;
    $display("FAIL");
    $finish;
  end

  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [PIX_W-1:0] shift_byte(logic [PIX_W-1:0] a, int d);
    return (int'(a) + d > 255) ? PIX_W'(int'(a) - d) : PIX_W'(int'(a) + d);
  endfunction

  // channel differences clustered at and just around the threshold
  function automatic pixel_pair_t near_pair(int thr);
    pixel_pair_t px;
    int d[3];
    int k;
    px = pixel_pair_t'(IN_DATA_W'({$urandom, $urandom}));
    k = $urandom_range(0, 2);
    foreach (d[i]) d[i] = $urandom_range(0, thr);
    d[k] = thr + $urandom_range(0, 2) - 1;
    if (d[k] < 0) d[k] = 0;
    if (d[k] > 255) d[k] = 255;
    px.second_blue  = shift_byte(px.first_blue, d[0]);
    px.second_green = shift_byte(px.first_green, d[1]);
    px.second_red   = shift_byte(px.first_red, d[2]);
    return px;
  endfunction

  function automatic pixel_pair_t pick_pair(int thr);
    pixel_pair_t px;
    int r;
    px = pixel_pair_t'(IN_DATA_W'({$urandom, $urandom}));
    r = $urandom_range(0, 9);
    if (r >= 4 && r < 8) begin
      px = near_pair(thr);
    end else if (r == 8) begin
      px.second_blue  = px.first_blue;
      px.second_green = px.first_green;
      px.second_red   = px.first_red;
    end else if (r == 9) begin
      px.first_blue   = {PIX_W{px.first_blue[0]}};
      px.first_green  = {PIX_W{px.first_green[0]}};
      px.first_red    = {PIX_W{px.first_red[0]}};
      px.second_blue  = {PIX_W{px.second_blue[0]}};
      px.second_green = {PIX_W{px.second_green[0]}};
      px.second_red   = {PIX_W{px.second_red[0]}};
    end
    return px;
  endfunction

  function automatic int frame_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) return $urandom_range(PIXEL_CAP + 2, PIXEL_CAP + 20);
    if (r < 20) return 1;
    return $urandom_range(2, 16);
  endfunction

  task automatic send_pixel(input pixel_pair_t px, input logic last, input bit steady);
    int gap;
    s_tdata <= {px.second_red, px.second_green, px.second_blue,
                px.first_red, px.first_green, px.first_blue};
    s_tlast <= last;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    gap = steady ? 0 : idle_cycles();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_bytes(input logic [7:0] fb, fg, fr, sb, sg, sr, input logic last);
    pixel_pair_t px;
    px = '{first_blue: fb, first_green: fg, first_red: fr,
           second_blue: sb, second_green: sg, second_red: sr};
    send_pixel(px, last, 1'b0);
    pixels_sent++;
  endtask

  task automatic send_frame(input int len, input int thr);
    bit steady;
    steady = ($urandom_range(0, 3) == 0);
    for (int n = 0; n < len; n++) send_pixel(pick_pair(thr), n == len - 1, steady);
    pixels_sent += len;
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic sel, input logic [PIX_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {sel, 2'b00};
    pwdata <= {24'($urandom_range(0, 16777215)), value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [PIX_W-1:0] thr, input logic [PIX_W-1:0] gain);
    apb_access(1'b1, REG_THRESHOLD, thr);
    apb_access(1'b1, REG_GAIN, gain);
    apb_access(1'b0, REG_THRESHOLD, '0);
    apb_access(1'b0, REG_GAIN, '0);
  endtask

  initial begin
    int on, off;
    m_tready <= 1'b0;
    @(posedge clk);
    forever begin
      on = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 8);
      off = idle_cycles();
      m_tready <= 1'b1;
      repeat (on) @(posedge clk);
      if (off > 0) begin
        m_tready <= 1'b0;
        repeat (off) @(posedge clk);
      end
    end
  end

  initial begin
    int thr, gain, target;
    rst <= 1'b1;
    s_tdata <= '0;
    s_tlast <= 1'b0;
    s_tvalid <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // corner pixels under the reset threshold and gain
    send_bytes(8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   1'b0);
    send_bytes(8'd255, 8'd255, 8'd255, 8'd0,   8'd0,   8'd0,   1'b0);
    send_bytes(8'd0,   8'd0,   8'd0,   8'd255, 8'd255, 8'd255, 1'b0);
    send_bytes(8'd8,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   1'b0);
    send_bytes(8'd0,   8'd9,   8'd0,   8'd0,   8'd0,   8'd0,   1'b0);
    send_bytes(8'd0,   8'd0,   8'd50,  8'd0,   8'd0,   8'd42,  1'b0);
    send_bytes(8'd1,   8'd2,   8'd3,   8'd4,   8'd5,   8'd6,   1'b0);
    send_bytes(8'd42,  8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   1'b0);
    send_bytes(8'd43,  8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   1'b1);
    send_bytes(8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   1'b1);
    send_bytes(8'd255, 8'd0,   8'd255, 8'd0,   8'd255, 8'd0,   1'b1);
    send_bytes(8'hAA,  8'h55,  8'hAA,  8'h55,  8'hAA,  8'h55,  1'b0);
    send_bytes(8'h55,  8'hAA,  8'h55,  8'hAA,  8'h55,  8'hAA,  1'b1);
    drain_results();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin thr = 0;   gain = 255; end
        1: begin thr = 255; gain = 0;   end
        2: begin thr = 0;   gain = 1;   end
        3: begin thr = 255; gain = 255; end
        7: begin thr = THRESHOLD_RESET; gain = GAIN_RESET; end
        default: begin
          thr = $urandom_range(0, 255);
          gain = $urandom_range(0, 1) ? $urandom_range(1, 12) : $urandom_range(0, 255);
        end
      endcase
      set_config(PIX_W'(thr), PIX_W'(gain));
      if (p == 0) send_frame(PIXEL_CAP + 16, thr);
      target = pixels_sent + 55;
      while (pixels_sent < target) send_frame(frame_length(), thr);
      drain_results();
    end

    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== pixel_diff_statistics_core.f =====
rtl/pds_pkg.sv
rtl/pds_pixel_math.sv
rtl/pixel_diff_statistics_core.sv
bench/diff_stats_checker.sv
bench/pixel_diff_statistics_core_test.sv
